@@ rtl/pft_pkg.sv @@
// pft_pkg: shared types and constants for the polygon fan triangulator
// item structs, controller/datapath command and status, step codes
// no dependencies
package pft_pkg;

  localparam int MAX_CORNERS = 64;
  localparam int MIN_CORNERS = 3;
  localparam int INDEX_BITS  = 20;
  localparam int COORD_BITS  = 16;

  localparam int COUNT_W = $clog2(MAX_CORNERS + 1);
  // corner differences, cross components, split halves for the shared multiplier
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int NORM_W  = 2 * DIFF_W + 1;
  localparam int LO_W    = NORM_W / 2;
  localparam int HI_W    = NORM_W - LO_W;
  localparam int MUL_W   = HI_W;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int ACC_W   = 2 * NORM_W + 2;

  // multiplier step codes: cross steps first, then dot steps
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_CROSS_FIRST = 5'd0;
  localparam logic [STEP_W-1:0] STEP_CROSS_LAST  = 5'd5;
  localparam logic [STEP_W-1:0] STEP_DOT_FIRST   = 5'd8;
  localparam logic [STEP_W-1:0] STEP_DOT_LAST    = 5'd19;

  // partial product of a dot step
  localparam logic [1:0] PART_HH = 2'd0;
  localparam logic [1:0] PART_HL = 2'd1;
  localparam logic [1:0] PART_LH = 2'd2;
  localparam logic [1:0] PART_LL = 2'd3;

  typedef struct packed {
    logic [INDEX_BITS-1:0]        vertex_index;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic                         polygon_end;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] corner_first;
    logic [INDEX_BITS-1:0] corner_second;
    logic [INDEX_BITS-1:0] corner_third;
    logic                  triangle_valid;
    logic                  order_swapped;
    logic                  too_few_corners;
    logic                  polygon_done;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DRAIN,
    S_FINISH
  } pft_state_t;

  typedef struct packed {
    logic              capture;
    logic              issue;
    logic [STEP_W-1:0] step;
    logic              finish;
  } pft_cmd_t;

  typedef struct packed {
    logic need_calc;
    logic count_two;
    logic out_free;
  } pft_status_t;

endpackage

@@ rtl/pft_controller.sv @@
// pft_controller: sequencer for one corner item
// drives capture, multiplier steps and finish; uses pft_pkg
module pft_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pft_pkg::pft_status_t status,
  output pft_pkg::pft_cmd_t    cmd
);

  pft_pkg::pft_state_t          state, state_next;
  logic [pft_pkg::STEP_W-1:0]   step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pft_pkg::S_IDLE;
      step  <= pft_pkg::STEP_CROSS_FIRST;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next  = state;
    step_next   = step;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.issue   = 1'b0;
    cmd.step    = step;
    cmd.finish  = 1'b0;
    unique case (state)
      pft_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          step_next   = pft_pkg::STEP_CROSS_FIRST;
          state_next  = status.need_calc ? pft_pkg::S_MUL : pft_pkg::S_FINISH;
        end
      end
      pft_pkg::S_MUL: begin
        cmd.issue = 1'b1;
        if (step == pft_pkg::STEP_CROSS_LAST) begin
          // the third corner only sets the reference normal
          if (status.count_two) begin
            state_next = pft_pkg::S_DRAIN;
          end else begin
            step_next = pft_pkg::STEP_DOT_FIRST;
          end
        end else if (step == pft_pkg::STEP_DOT_LAST) begin
          state_next = pft_pkg::S_DRAIN;
        end else begin
          step_next = step + 1'b1;
        end
      end
      pft_pkg::S_DRAIN: begin
        state_next = pft_pkg::S_FINISH;
      end
      pft_pkg::S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = pft_pkg::S_IDLE;
        end
      end
      default: state_next = pft_pkg::S_IDLE;
    endcase
  end

endmodule

@@ rtl/pft_datapath.sv @@
// pft_datapath: corner registers, shared multiplier, normal and dot accumulators,
// output register; controlled by pft_controller, uses pft_pkg
module pft_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  pft_pkg::in_item_t    in_data,
  input  pft_pkg::pft_cmd_t    cmd,
  output pft_pkg::pft_status_t status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pft_pkg::out_item_t   out_data
);

  pft_pkg::in_item_t                        cur;
  logic [pft_pkg::COUNT_W-1:0]              count;
  logic [pft_pkg::INDEX_BITS-1:0]           first_idx;
  logic [pft_pkg::INDEX_BITS-1:0]           prev_idx;
  logic signed [pft_pkg::COORD_BITS-1:0]    first_pos [3];
  logic signed [pft_pkg::COORD_BITS-1:0]    prev_pos  [3];
  logic signed [pft_pkg::COORD_BITS-1:0]    cur_pos   [3];
  logic [pft_pkg::NORM_W-1:0]               ref_n [3];
  logic [pft_pkg::NORM_W-1:0]               cur_n [3];
  logic [pft_pkg::DIFF_W-1:0]               u [3];
  logic [pft_pkg::DIFF_W-1:0]               v [3];

  logic [pft_pkg::MUL_W-1:0]                op_a, op_b;
  logic signed [pft_pkg::PROD_W-1:0]        prod;
  logic                                     prod_vld;
  logic [pft_pkg::STEP_W-1:0]               prod_step;
  logic signed [pft_pkg::ACC_W-1:0]         acc;
  logic signed [pft_pkg::ACC_W-1:0]         prod_ext;
  logic signed [pft_pkg::ACC_W-1:0]         term;

  logic [3:0]                               dstep, dstep_d;
  logic [pft_pkg::NORM_W-1:0]               sel_n, sel_r;

  logic                                     active, calc, swapped, emit;
  logic [pft_pkg::COUNT_W-1:0]              count_after;

  assign cur_pos[0] = cur.pos_x;
  assign cur_pos[1] = cur.pos_y;
  assign cur_pos[2] = cur.pos_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      u[k] = {prev_pos[k][pft_pkg::COORD_BITS-1], prev_pos[k]}
           - {first_pos[k][pft_pkg::COORD_BITS-1], first_pos[k]};
      v[k] = {cur_pos[k][pft_pkg::COORD_BITS-1], cur_pos[k]}
           - {first_pos[k][pft_pkg::COORD_BITS-1], first_pos[k]};
    end
  end

  // operand select for the issued step
  assign dstep = 4'(cmd.step - pft_pkg::STEP_DOT_FIRST);
  assign sel_n = cur_n[dstep[3:2]];
  assign sel_r = ref_n[dstep[3:2]];

  function automatic logic [pft_pkg::MUL_W-1:0] sx_diff(input logic [pft_pkg::DIFF_W-1:0] d);
    sx_diff = {{(pft_pkg::MUL_W - pft_pkg::DIFF_W){d[pft_pkg::DIFF_W-1]}}, d};
  endfunction

  always_comb begin
    op_a = '0;
    op_b = '0;
    if (cmd.step < pft_pkg::STEP_DOT_FIRST) begin
      unique case (cmd.step[2:0])
        3'd0:    begin op_a = sx_diff(u[1]); op_b = sx_diff(v[2]); end
        3'd1:    begin op_a = sx_diff(u[2]); op_b = sx_diff(v[1]); end
        3'd2:    begin op_a = sx_diff(u[2]); op_b = sx_diff(v[0]); end
        3'd3:    begin op_a = sx_diff(u[0]); op_b = sx_diff(v[2]); end
        3'd4:    begin op_a = sx_diff(u[0]); op_b = sx_diff(v[1]); end
        3'd5:    begin op_a = sx_diff(u[1]); op_b = sx_diff(v[0]); end
        default: begin op_a = '0; op_b = '0; end
      endcase
    end else begin
      // high half signed, low half zero extended
      unique case (dstep[1:0])
        pft_pkg::PART_HH: begin
          op_a = sel_n[pft_pkg::NORM_W-1:pft_pkg::LO_W];
          op_b = sel_r[pft_pkg::NORM_W-1:pft_pkg::LO_W];
        end
        pft_pkg::PART_HL: begin
          op_a = sel_n[pft_pkg::NORM_W-1:pft_pkg::LO_W];
          op_b = {1'b0, sel_r[pft_pkg::LO_W-1:0]};
        end
        pft_pkg::PART_LH: begin
          op_a = {1'b0, sel_n[pft_pkg::LO_W-1:0]};
          op_b = sel_r[pft_pkg::NORM_W-1:pft_pkg::LO_W];
        end
        pft_pkg::PART_LL: begin
          op_a = {1'b0, sel_n[pft_pkg::LO_W-1:0]};
          op_b = {1'b0, sel_r[pft_pkg::LO_W-1:0]};
        end
        default: begin op_a = '0; op_b = '0; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod      <= $signed(op_a) * $signed(op_b);
    prod_step <= cmd.step;
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= cmd.issue;
    end
  end

  // dot partial placed at its weight
  assign dstep_d  = 4'(prod_step - pft_pkg::STEP_DOT_FIRST);
  assign prod_ext = pft_pkg::ACC_W'(prod);
  always_comb begin
    unique case (dstep_d[1:0])
      pft_pkg::PART_HH: term = prod_ext <<< (2 * pft_pkg::LO_W);
      pft_pkg::PART_HL: term = prod_ext <<< pft_pkg::LO_W;
      pft_pkg::PART_LH: term = prod_ext <<< pft_pkg::LO_W;
      pft_pkg::PART_LL: term = prod_ext;
      default:          term = prod_ext;
    endcase
  end

  always_ff @(posedge clk) begin
    if (prod_vld) begin
      if (prod_step < pft_pkg::STEP_DOT_FIRST) begin
        if (prod_step[0]) begin
          cur_n[prod_step[2:1]] <= cur_n[prod_step[2:1]] - prod[pft_pkg::NORM_W-1:0];
        end else begin
          cur_n[prod_step[2:1]] <= prod[pft_pkg::NORM_W-1:0];
        end
      end else if (dstep_d == 4'd0) begin
        acc <= term;
      end else begin
        acc <= acc + term;
      end
    end
  end

  // finish decisions on the count before this corner
  assign active      = count < pft_pkg::COUNT_W'(pft_pkg::MAX_CORNERS);
  assign calc        = active && (count >= pft_pkg::COUNT_W'(2));
  assign swapped     = calc && (count >= pft_pkg::COUNT_W'(3)) && acc[pft_pkg::ACC_W-1];
  assign emit        = calc || cur.polygon_end;
  assign count_after = count + pft_pkg::COUNT_W'(active);

  assign status.need_calc = calc;
  assign status.count_two = (count == pft_pkg::COUNT_W'(2));
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur <= in_data;
    end
    if (rst) begin
      count     <= '0;
      first_idx <= '0;
      prev_idx  <= '0;
      for (int k = 0; k < 3; k++) begin
        first_pos[k] <= '0;
        prev_pos[k]  <= '0;
        ref_n[k]     <= '0;
      end
    end else if (cmd.finish) begin
      if (active) begin
        if (count == '0) begin
          first_idx <= cur.vertex_index;
          for (int k = 0; k < 3; k++) first_pos[k] <= cur_pos[k];
        end
        if (count == pft_pkg::COUNT_W'(2)) begin
          for (int k = 0; k < 3; k++) ref_n[k] <= cur_n[k];
        end
        prev_idx <= cur.vertex_index;
        for (int k = 0; k < 3; k++) prev_pos[k] <= cur_pos[k];
      end
      count <= cur.polygon_end ? '0 : count_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.finish && emit) begin
      out_data.corner_first    <= calc ? first_idx : '0;
      out_data.corner_second   <= calc ? (swapped ? cur.vertex_index : prev_idx) : '0;
      out_data.corner_third    <= calc ? (swapped ? prev_idx : cur.vertex_index) : '0;
      out_data.triangle_valid  <= calc;
      out_data.order_swapped   <= swapped;
      out_data.too_few_corners <= cur.polygon_end
                                  && (count_after < pft_pkg::COUNT_W'(pft_pkg::MIN_CORNERS));
      out_data.polygon_done    <= cur.polygon_end;
    end
  end

endmodule

@@ rtl/polygon_fan_triangulator.sv @@
// result registered at finish: straight after acceptance with no triangle, else after the
// multiplier steps and a drain; one shared 18x18 multiplier runs 6 cross steps, then 12
// dot partials from the fourth corner on
// one corner at a time, finish waits for a free output; next corner taken while a result waits
// reset: synchronous rst clears the corner count, stored corners and reference normal
// top level: pft_controller and pft_datapath; uses pft_pkg
module polygon_fan_triangulator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pft_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pft_pkg::out_item_t out_data
);

  pft_pkg::pft_cmd_t    cmd;
  pft_pkg::pft_status_t status;

  pft_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pft_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
